/* sv/encoder_led_frame_composer_defines.svh */
// assertion macros for the led frame composer checker
`ifndef ENCODER_LED_FRAME_COMPOSER_DEFINES_SVH
`define ENCODER_LED_FRAME_COMPOSER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ELFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("elfc checker: property violated");

// next-cycle implication, sampled on clk_i, off during reset
`define ELFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("elfc checker: property violated");

`endif

/* sv/elfc_pkg.sv */
// shared types and constants of the led frame composer
`timescale 1ns / 1ps
`default_nettype none

package elfc_pkg;

  localparam int unsigned SectionsDef = 3;
  localparam int unsigned ColorW      = 8;
  localparam int unsigned ColW        = 5;
  localparam int unsigned RowW        = 3;
  localparam int unsigned IdxW        = 8;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned PixelW      = 3 * ColorW;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLACE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // fade window and reciprocal constants
  localparam logic [TimeW-1:0] FadeWindowUs  = 32'd2000000;
  localparam logic [11:0]      FadeFullMs    = 12'd4000;
  localparam logic [31:0]      RecipMs       = 32'd2199023256;
  localparam int unsigned      RecipMsShift  = 41;
  localparam logic [30:0]      RecipFull     = 31'd1099511628;
  localparam int unsigned      RecipFullShift = 42;

  typedef struct packed {
    logic clr;
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* sv/elfc_fade.sv */
// three-stage colour fade pipeline
`timescale 1ns / 1ps
`default_nettype none

module elfc_fade import elfc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ColorW-1:0] red_i,
  input  wire logic [ColorW-1:0] green_i,
  input  wire logic [ColorW-1:0] blue_i,
  input  wire logic [TimeW-1:0]  elapsed_us_i,
  output logic                   done_o,
  output logic [PixelW-1:0]      pixel_o
);

  logic                          win;
  logic [52:0]                   prod1_d;
  logic                          v1_q, v2_q, v3_q;
  logic                          win1_q, win2_q;
  logic [52:0]                   prod1_q;
  logic [2:0][ColorW-1:0]        rgb1_q;
  logic [2:0][ColorW-2:0]        half1_q, half2_q;
  logic [10:0]                   q_ms;
  logic [11:0]                   num;
  logic [2:0][19:0]              y_d, y2_q;
  logic [2:0][50:0]              z_full;
  logic [2:0][ColorW-1:0]        out_q;

  assign win = !elapsed_us_i[TimeW-1] && (elapsed_us_i != '0) && (elapsed_us_i < FadeWindowUs);
  assign prod1_d = elapsed_us_i[20:0] * RecipMs;

  assign q_ms = prod1_q[RecipMsShift +: 11];
  assign num  = FadeFullMs - {1'b0, q_ms};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y_d[i]    = rgb1_q[i] * num;
      z_full[i] = y2_q[i] * RecipFull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod1_q   <= prod1_d;
      win1_q    <= win;
      rgb1_q    <= {red_i, green_i, blue_i};
      half1_q   <= {red_i[ColorW-1:1], green_i[ColorW-1:1], blue_i[ColorW-1:1]};
    end
    if (v1_q) begin
      y2_q    <= y_d;
      win2_q  <= win1_q;
      half2_q <= half1_q;
    end
    if (v2_q) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i] <= win2_q ? z_full[i][RecipFullShift +: ColorW] : {1'b0, half2_q[i]};
      end
    end
  end

  assign done_o  = v3_q;
  assign pixel_o = out_q;

endmodule

`default_nettype wire

/* sv/elfc_frame_mem.sv */
// frame memory, one write port and one read port, with per-pixel valid bits for clear
`timescale 1ns / 1ps
`default_nettype none

module elfc_frame_mem import elfc_pkg::*; #(
  parameter  int unsigned PIXELS = 48 * SectionsDef,
  localparam int unsigned AddrW  = $clog2(PIXELS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mem_ctl_t          ctl_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [PixelW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic [PixelW-1:0]      rdata_o
);

  logic [PixelW-1:0] mem_q [PIXELS];
  logic [PIXELS-1:0] valid_q;
  logic [PixelW-1:0] rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.we) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.re) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* sv/encoder_led_frame_composer.sv */
// top level of the encoder led frame composer
// clear: no result, and the input is not stalled; place: the fade result is written to one
//   address for rows 0 and 1 and to two for rows 2 and 3, nothing when the item writes nothing
// read: the memory data is registered, then the output register loads once it is free;
//   input stalls until it moves into the output register; one item in flight at a time
// reset: async active low, clears the pixel valid bits so the frame reads as zero
`timescale 1ns / 1ps
`default_nettype none

module encoder_led_frame_composer import elfc_pkg::*; #(
  parameter int unsigned SECTIONS = SectionsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [ColW-1:0]   encoder_column_i,
  input  wire logic [RowW-1:0]   encoder_row_i,
  input  wire logic [ColorW-1:0] red_i,
  input  wire logic [ColorW-1:0] green_i,
  input  wire logic [ColorW-1:0] blue_i,
  input  wire logic [TimeW-1:0]  elapsed_us_i,
  input  wire logic [IdxW-1:0]   pixel_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ColorW-1:0]      pixel_red_o,
  output logic [ColorW-1:0]      pixel_green_o,
  output logic [ColorW-1:0]      pixel_blue_o,
  output logic [IdxW-1:0]        pixel_number_o
);

  localparam int unsigned Width    = 6 * SECTIONS;
  localparam int unsigned Pixels   = 8 * Width;
  localparam int unsigned AddrW    = $clog2(Pixels);
  localparam int unsigned CmpW     = (AddrW > IdxW) ? AddrW : IdxW;
  localparam int unsigned ColLimit = 5 * SECTIONS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FADE = 4'b0010,
    ST_WR_B = 4'b0100,
    ST_READ = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  mem_ctl_t            ctl;
  logic [AddrW-1:0]    waddr;
  logic [PixelW-1:0]   rdata;
  logic [PixelW-1:0]   fade_pixel;
  logic                fade_start, fade_done;
  logic                in_acc, out_free, load_out;
  logic [CmpW-1:0]     idx_w;
  logic                in_range;
  logic [8:0]          col_x13;
  logic [AddrW-1:0]    pc;
  logic                col_ok, row_ok, place_ok;
  logic [AddrW-1:0]    addr_a_d, addr_b_d, addr_a_q, addr_b_q;
  logic                two_d, two_q;
  logic                rd_ok_q;
  logic [IdxW-1:0]     num_q;
  logic [IdxW-1:0]     out_num_q;
  logic                out_valid_q;
  logic [PixelW-1:0]   out_pixel_q;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign idx_w    = CmpW'(pixel_index_i);
  assign in_range = idx_w < CmpW'(Pixels);

  // gap column after every five: pc = col + col / 5
  assign col_x13  = 9'(encoder_column_i) * 9'd13;
  assign pc       = AddrW'(encoder_column_i) + AddrW'(col_x13[8:6]);
  assign col_ok   = 6'(encoder_column_i) < 6'(ColLimit);
  assign row_ok   = encoder_row_i inside {[3'd0:3'd3]};
  assign place_ok = col_ok && row_ok;

  always_comb begin
    addr_a_d = pc;
    addr_b_d = pc;
    two_d    = 1'b0;
    case (encoder_row_i[1:0])
      2'd0: begin
        addr_a_d = AddrW'(7 * Width) + pc;
      end
      2'd1: begin
        addr_a_d = AddrW'(6 * Width) + pc;
      end
      2'd2: begin
        addr_a_d = AddrW'(3 * Width) + pc;
        addr_b_d = AddrW'(2 * Width) + pc;
        two_d    = 1'b1;
      end
      2'd3: begin
        addr_a_d = AddrW'(Width) + pc;
        addr_b_d = pc;
        two_d    = 1'b1;
      end
      default: begin
        two_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    ctl        = '0;
    waddr      = addr_a_q;
    fade_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(op_i))
            OP_CLEAR: begin
              ctl.clr = 1'b1;
            end
            OP_PLACE: begin
              if (place_ok) begin
                fade_start = 1'b1;
                state_d    = ST_FADE;
              end
            end
            OP_READ: begin
              ctl.re  = in_range;
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FADE: begin
        if (fade_done) begin
          ctl.we  = 1'b1;
          waddr   = addr_a_q;
          state_d = two_q ? ST_WR_B : ST_IDLE;
        end
      end
      ST_WR_B: begin
        ctl.we  = 1'b1;
        waddr   = addr_b_q;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fade_start) begin
      addr_a_q <= addr_a_d;
      addr_b_q <= addr_b_d;
      two_q    <= two_d;
    end
    if (in_acc && (op_e'(op_i) == OP_READ)) begin
      rd_ok_q <= in_range;
      num_q   <= pixel_index_i;
    end
    if (load_out) begin
      out_pixel_q <= rd_ok_q ? rdata : '0;
      out_num_q   <= num_q;
    end
  end

  elfc_fade u_fade (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (fade_start),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .elapsed_us_i (elapsed_us_i),
    .done_o       (fade_done),
    .pixel_o      (fade_pixel)
  );

  elfc_frame_mem #(
    .PIXELS (Pixels)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .waddr_i (waddr),
    .wdata_i (fade_pixel),
    .raddr_i (idx_w[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pixel_red_o    = out_pixel_q[2*ColorW +: ColorW];
  assign pixel_green_o  = out_pixel_q[ColorW +: ColorW];
  assign pixel_blue_o   = out_pixel_q[0 +: ColorW];
  assign pixel_number_o = out_num_q;

endmodule

`default_nettype wire

/* sv/elfc_checker.sv */
// port-level checker for the led frame composer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "encoder_led_frame_composer_defines.svh"

module elfc_checker import elfc_pkg::*; #(
  parameter int unsigned SECTIONS = SectionsDef
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [1:0]        op_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [ColorW-1:0] pixel_red_o,
  input wire logic [ColorW-1:0] pixel_green_o,
  input wire logic [ColorW-1:0] pixel_blue_o,
  input wire logic [IdxW-1:0]   pixel_number_o
);

  localparam int unsigned Pixels = 48 * SECTIONS;
  localparam int unsigned CmpW   = 10;

  logic in_acc;
  logic rd_acc;
  logic beyond;
  logic blank;

  assign in_acc = in_valid_i && !in_stall_o;
  assign rd_acc = in_acc && (op_i == OP_READ);
  assign beyond = out_valid_o && (CmpW'(pixel_number_o) >= CmpW'(Pixels));
  assign blank  = (pixel_red_o == '0) && (pixel_green_o == '0) && (pixel_blue_o == '0);

  // a stalled result stays
  `ELFC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // read with an empty output register: result after the ST_READ state
  `ELFC_ASSERT_NOW(a_read_resp, rd_acc && !out_valid_o, ##2 out_valid_o)
  // after a clear the input is not stalled in the next cycle
  `ELFC_ASSERT_NEXT(a_clear_fast, in_acc && (op_i == OP_CLEAR), !in_stall_o)
  // reads beyond the frame return black
  `ELFC_ASSERT_NOW(a_beyond_zero, beyond, blank)

endmodule

bind encoder_led_frame_composer elfc_checker #(.SECTIONS(SECTIONS)) u_elfc_checker (.*);

`default_nettype wire
